// ===== design/mwo_pkg.sv =====
// Shared types and constants for the multi-waveform oscillator.
// Depends on nothing; imported by the step logic and the top level.
package mwo_pkg;

    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_INDEX_BITS = 3;
    localparam int STEP_BITS = 26;

    localparam logic signed [31:0] ONE_Q24 = 32'sd16777216;
    localparam logic signed [31:0] MINUS_ONE_Q24 = -32'sd16777216;
    localparam logic [31:0] COUNT_STEP = 32'd256;

    localparam logic [1:0] MODE_SINE = 2'd0;
    localparam logic [1:0] MODE_PULSE = 2'd1;
    localparam logic [1:0] MODE_TRIANGLE = 2'd2;
    localparam logic [1:0] MODE_SAW = 2'd3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_WAVE_MODE  = 3'd0,
        REG_CYCLE_LEN  = 3'd1,
        REG_PULSE_LEN  = 3'd2,
        REG_RISE_LEN   = 3'd3,
        REG_RISE_STEP  = 3'd4,
        REG_FALL_STEP  = 3'd5,
        REG_PHASE_STEP = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]           wave_mode;
        logic [31:0]          cycle_len;
        logic [31:0]          pulse_len;
        logic [31:0]          rise_len;
        logic [STEP_BITS-1:0] rise_step;
        logic [STEP_BITS-1:0] fall_step;
        logic [31:0]          phase_step;
    } cfg_t;

    typedef struct packed {
        logic [31:0]        cycle_count;
        logic signed [31:0] level;
        logic [31:0]        phase;
    } osc_state_t;

endpackage

// ===== design/mwo_if.sv =====
// Handshake channel interfaces of the oscillator: tick in, sample out, register writes.
// Depends on mwo_pkg for the register write widths.
interface mwo_tick_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink (input valid, input tick, output ready);
endinterface

interface mwo_sample_if #(
    parameter int W = 16
);
    logic         valid;
    logic         ready;
    logic [W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface mwo_cfg_if;
    import mwo_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/mwo_step.sv =====
// Next-state logic for one sample: count wrap, phase advance, level stepping.
// Depends on mwo_pkg for the register and state structs.
module mwo_step (
    input  mwo_pkg::cfg_t       cfg,
    input  mwo_pkg::osc_state_t cur,
    output mwo_pkg::osc_state_t nxt,
    output logic signed [31:0]  shown
);
    import mwo_pkg::*;

    localparam logic signed [33:0] MAX32 = 34'sd2147483647;
    localparam logic signed [33:0] MIN32 = -34'sd2147483648;

    logic               rising;
    logic signed [31:0] clamped;
    logic signed [33:0] stepped;
    logic signed [31:0] level_sat;
    logic [32:0]        count_sum;
    logic               ends;

    always_comb
    begin
        rising = (cfg.wave_mode == MODE_TRIANGLE) && (cur.cycle_count < cfg.rise_len);

        // clamp at the turning point, then step by the active slope
        if (rising)
        begin
            clamped = (cur.level <= MINUS_ONE_Q24) ? MINUS_ONE_Q24 : cur.level;
            stepped = 34'(clamped) + $signed({8'd0, cfg.rise_step});
        end
        else
        begin
            clamped = (cur.level >= ONE_Q24) ? ONE_Q24 : cur.level;
            stepped = 34'(clamped) - $signed({8'd0, cfg.fall_step});
        end

        if (stepped > MAX32)
            level_sat = 32'sd2147483647;
        else if (stepped < MIN32)
            level_sat = -32'sd2147483648;
        else
            level_sat = stepped[31:0];

        count_sum = {1'b0, cur.cycle_count} + {1'b0, COUNT_STEP};
        ends = count_sum >= {1'b0, cfg.cycle_len};

        nxt.cycle_count = ends ? 32'd0 : count_sum[31:0];
        nxt.phase = cur.phase + cfg.phase_step;

        case (cfg.wave_mode)
            MODE_PULSE:
            begin
                shown = (cur.cycle_count < cfg.pulse_len) ? 32'sd0 : ONE_Q24;
                nxt.level = cur.level;
            end
            MODE_TRIANGLE:
            begin
                shown = clamped;
                nxt.level = level_sat;
            end
            MODE_SAW:
            begin
                shown = clamped;
                nxt.level = ends ? ONE_Q24 : level_sat;
            end
            default:
            begin
                shown = 32'sd0;
                nxt.level = cur.level;
            end
        endcase
    end

endmodule

// ===== design/multi_waveform_oscillator_core.sv =====
// Top level of the multi-waveform oscillator: registers, state, sine ROM, output stage.
// Depends on mwo_pkg, the channel interfaces in mwo_if and the step logic in mwo_step.
//
//  channel   dir  payload               transaction meaning
//  --------  ---  --------------------  ----------------------------------------
//  ticks     in   tick (1 bit)          one sample period; tick 0 is dropped
//  samples   out  sample (SAMPLE_BITS)  signed Q1.(SAMPLE_BITS-1) sample
//  cfg       in   index (3), data (32)  register write, unknown index ignored
//
// One tick per cycle while the sink keeps up. A tick of 1 yields its sample in the
// next cycle: the sine ROM read and the sample conversion land in the output register.
// ticks.ready is high whenever the output register is empty or being drained, so a
// stalled sample holds and back-pressure reaches the input in the same cycle.
// Reset (rst_n low, asynchronous) restores the register defaults and the waveform
// start; cfg.ready is always high.
module multi_waveform_oscillator_core #(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    mwo_tick_if.sink        ticks,
    mwo_sample_if.source    samples,
    mwo_cfg_if.sink         cfg
);
    import mwo_pkg::*;

    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
    localparam int DEPTH_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int SHIFT = 25 - SAMPLE_BITS;
    localparam logic signed [31:0] SAMPLE_HI = 32'sd2 ** (SAMPLE_BITS - 1) - 32'sd1;
    localparam logic signed [31:0] SAMPLE_LO = -SAMPLE_HI - 32'sd1;
    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam int TERMS = 8;

    typedef logic [SAMPLE_BITS-1:0] rom_t [SINE_TABLE_DEPTH];

    // Q8.24 level to sample code: floor shift, then saturate
    function automatic logic [SAMPLE_BITS-1:0] to_sample(input logic signed [31:0] v);
        logic signed [31:0] q;
        q = v >>> SHIFT;
        if (q > SAMPLE_HI)
            q = SAMPLE_HI;
        if (q < SAMPLE_LO)
            q = SAMPLE_LO;
        return q[SAMPLE_BITS-1:0];
    endfunction

    // sin of x in Q30 over the first quarter turn, Taylor series
    function automatic longint sin_quarter(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint unsigned prod;
        longint          sum;
        x2 = (x * x) >> 30;
        term = x;
        sum = longint'(x);
        for (int n = 1; n < TERMS; n++)
        begin
            prod = (term * x2) >> 30;
            // next odd term: divide by (2n)(2n+1)
            case (n)
                1:       term = prod / 64'd6;
                2:       term = prod / 64'd20;
                3:       term = prod / 64'd42;
                4:       term = prod / 64'd72;
                5:       term = prod / 64'd110;
                6:       term = prod / 64'd156;
                default: term = prod / 64'd210;
            endcase
            if (n % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        return sum;
    endfunction

    // sine samples, built at elaboration
    function automatic rom_t build_rom();
        rom_t              rom;
        longint unsigned   a;
        logic              neg;
        longint            s;
        longint unsigned   m;
        logic signed [31:0] entry;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
        begin
            a = (64'd2 * PI_Q30 * longint'(k)) / SINE_TABLE_DEPTH;
            neg = 1'b0;
            if (a > PI_Q30)
            begin
                a = a - PI_Q30;
                neg = 1'b1;
            end
            if (a > PI_Q30 / 2)
                a = PI_Q30 - a;
            s = sin_quarter(a);
            if (s < 0)
                s = 0;
            m = (longint'(s) + 64'd32) >> 6;
            entry = neg ? -$signed(m[31:0]) : $signed(m[31:0]);
            rom[k] = to_sample(entry);
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    cfg_t                   cfg_reg;
    osc_state_t             state_reg;
    osc_state_t             state_next;
    logic signed [31:0]     shown;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   out_valid_reg;
    logic                   in_accept;
    logic                   emit;
    logic                   cfg_write;
    logic [32+DEPTH_W-1:0]  phase_prod;
    logic [IDX_W-1:0]       rom_idx;

    mwo_step u_step (
        .cfg   (cfg_reg),
        .cur   (state_reg),
        .nxt   (state_next),
        .shown (shown)
    );

    assign ticks.ready = !out_valid_reg || samples.ready;
    assign in_accept = ticks.valid && ticks.ready;
    assign emit = in_accept && ticks.tick;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid;

    assign samples.valid = out_valid_reg;
    assign samples.sample = sample_reg;

    // table index is the top bits of phase scaled by the depth
    assign phase_prod = {{DEPTH_W{1'b0}}, state_reg.phase}
                        * (32 + DEPTH_W)'(SINE_TABLE_DEPTH);
    assign rom_idx = phase_prod[32 +: IDX_W];

    // register file and oscillator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wave_mode <= MODE_SINE;
            cfg_reg.cycle_len <= 32'd25600;
            cfg_reg.pulse_len <= 32'd12800;
            cfg_reg.rise_len <= 32'd12800;
            cfg_reg.rise_step <= STEP_BITS'(335544);
            cfg_reg.fall_step <= STEP_BITS'(335544);
            cfg_reg.phase_step <= 32'd42949673;
            state_reg.cycle_count <= 32'd0;
            state_reg.level <= MINUS_ONE_Q24;
            state_reg.phase <= 32'd0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx_t'(cfg.index))
                REG_WAVE_MODE:
                begin
                    // mode change restarts the waveform
                    cfg_reg.wave_mode <= cfg.data[1:0];
                    state_reg.cycle_count <= 32'd0;
                    state_reg.phase <= 32'd0;
                    state_reg.level <= (cfg.data[1:0] == MODE_SAW) ? ONE_Q24 : MINUS_ONE_Q24;
                end
                REG_CYCLE_LEN:  cfg_reg.cycle_len <= cfg.data;
                REG_PULSE_LEN:  cfg_reg.pulse_len <= cfg.data;
                REG_RISE_LEN:   cfg_reg.rise_len <= cfg.data;
                REG_RISE_STEP:  cfg_reg.rise_step <= cfg.data[STEP_BITS-1:0];
                REG_FALL_STEP:  cfg_reg.fall_step <= cfg.data[STEP_BITS-1:0];
                REG_PHASE_STEP: cfg_reg.phase_step <= cfg.data;
                default:        ;
            endcase
        end
        else if (emit)
        begin
            state_reg <= state_next;
        end
    end

    // output stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (samples.ready)
            out_valid_reg <= 1'b0;
    end

    // output payload: registered ROM read for sine, converted level otherwise
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            if (cfg_reg.wave_mode == MODE_SINE)
                sample_reg <= SINE_ROM[rom_idx];
            else
                sample_reg <= to_sample(shown);
        end
    end

endmodule

// ===== bench/mwo_sample_checker.sv =====
// Sample checker of the multi-waveform oscillator: watches the tick, sample and
// register channels, predicts each sample and compares it. Depends on mwo_pkg and mwo_if.
`timescale 1ns / 100ps

module mwo_sample_checker #(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic  clk,
    input  logic  rst_n,
    mwo_tick_if   ticks,
    mwo_sample_if samples,
    mwo_cfg_if    cfg,
    output int    errors,
    output int    pending
);
    import mwo_pkg::*;

    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam int SERIES_TERMS = 8;
    localparam int REPORT_LIMIT = 50;
    localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

    localparam logic [31:0] RST_CYCLE_LEN = 32'd25600;
    localparam logic [31:0] RST_PULSE_LEN = 32'd12800;
    localparam logic [31:0] RST_RISE_LEN = 32'd12800;
    localparam logic [STEP_BITS-1:0] RST_STEP = STEP_BITS'(335544);
    localparam logic [31:0] RST_PHASE_STEP = 32'd42949673;

    logic signed [31:0] sine_rom [SINE_TABLE_DEPTH];

    logic [1:0]           cfg_mode;
    logic [31:0]          cfg_cycle_len;
    logic [31:0]          cfg_pulse_len;
    logic [31:0]          cfg_rise_len;
    logic [STEP_BITS-1:0] cfg_rise_step;
    logic [STEP_BITS-1:0] cfg_fall_step;
    logic [31:0]          cfg_phase_step;

    logic [31:0]        osc_count;
    logic signed [31:0] osc_level;
    logic [31:0]        osc_phase;

    logic [SAMPLE_BITS-1:0] expected_samples [$];
    int fail_count = 0;

    assign errors = fail_count;
    assign pending = expected_samples.size();

    // sin(x) for 0 <= x <= pi/2, Q2.30 in and out, truncated Taylor series
    function automatic longint sin_q30(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint unsigned divisor;
        longint acc;
        x2 = (x * x) >> 30;
        term = x;
        acc = x;
        for (int n = 1; n < SERIES_TERMS; n++) begin
            divisor = (2 * n) * (2 * n + 1);
            term = ((term * x2) >> 30) / divisor;
            if (n % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        return acc;
    endfunction

    initial begin : build_rom
        longint unsigned angle;
        longint unsigned mag;
        longint s;
        bit neg;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            angle = (2 * PI_Q30 * longint'(k)) / SINE_TABLE_DEPTH;
            neg = 1'b0;
            if (angle > PI_Q30) begin
                angle = angle - PI_Q30;
                neg = 1'b1;
            end
            if (angle > PI_Q30 / 2)
                angle = PI_Q30 - angle;
            s = sin_q30(angle);
            if (s < 0)
                s = 0;
            mag = (longint'(s) + 32) >> 6;
            sine_rom[k] = neg ? -32'(mag) : 32'(mag);
        end
    end

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return 32'(v);
    endfunction

    // Q8.24 level to a saturated sample, rounding toward minus infinity
    function automatic logic [SAMPLE_BITS-1:0] level_to_sample(input logic signed [31:0] lv);
        longint q;
        q = longint'(lv) >>> (25 - SAMPLE_BITS);
        if (q > SAMPLE_MAX)
            q = SAMPLE_MAX;
        if (q < SAMPLE_MIN)
            q = SAMPLE_MIN;
        return q[SAMPLE_BITS-1:0];
    endfunction

    function automatic void restart_wave();
        osc_count = '0;
        osc_phase = '0;
        osc_level = (cfg_mode == MODE_SAW) ? ONE_Q24 : MINUS_ONE_Q24;
    endfunction

    // Form the sample of this tick, then advance count, phase and level
    function automatic logic [SAMPLE_BITS-1:0] osc_next_sample();
        logic signed [31:0] shown;
        logic [32:0] next_count;
        longint unsigned rom_idx;
        bit rising;
        bit wraps;
        if (cfg_mode == MODE_SINE) begin
            rom_idx = ({32'd0, osc_phase} * 64'(SINE_TABLE_DEPTH)) >> 32;
            shown = sine_rom[rom_idx % SINE_TABLE_DEPTH];
        end else if (cfg_mode == MODE_PULSE) begin
            shown = (osc_count < cfg_pulse_len) ? 32'sd0 : ONE_Q24;
        end else begin
            rising = (cfg_mode == MODE_TRIANGLE) && (osc_count < cfg_rise_len);
            if (rising) begin
                if (osc_level <= MINUS_ONE_Q24)
                    osc_level = MINUS_ONE_Q24;
                shown = osc_level;
                osc_level = clip32(longint'(osc_level) + longint'(cfg_rise_step));
            end else begin
                if (osc_level >= ONE_Q24)
                    osc_level = ONE_Q24;
                shown = osc_level;
                osc_level = clip32(longint'(osc_level) - longint'(cfg_fall_step));
            end
        end
        next_count = {1'b0, osc_count} + {1'b0, COUNT_STEP};
        wraps = next_count >= {1'b0, cfg_cycle_len};
        osc_count = wraps ? 32'd0 : next_count[31:0];
        if (wraps && cfg_mode == MODE_SAW)
            osc_level = ONE_Q24;
        osc_phase = osc_phase + cfg_phase_step;
        return level_to_sample(shown);
    endfunction

    function automatic void apply_write(input logic [CFG_INDEX_BITS-1:0] idx,
                                        input logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            REG_WAVE_MODE: begin
                cfg_mode = data[1:0];
                restart_wave();
            end
            REG_CYCLE_LEN:  cfg_cycle_len = data;
            REG_PULSE_LEN:  cfg_pulse_len = data;
            REG_RISE_LEN:   cfg_rise_len = data;
            REG_RISE_STEP:  cfg_rise_step = data[STEP_BITS-1:0];
            REG_FALL_STEP:  cfg_fall_step = data[STEP_BITS-1:0];
            REG_PHASE_STEP: cfg_phase_step = data;
            default: ;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        logic [SAMPLE_BITS-1:0] want;
        if (!rst_n) begin
            cfg_mode = MODE_SINE;
            cfg_cycle_len = RST_CYCLE_LEN;
            cfg_pulse_len = RST_PULSE_LEN;
            cfg_rise_len = RST_RISE_LEN;
            cfg_rise_step = RST_STEP;
            cfg_fall_step = RST_STEP;
            cfg_phase_step = RST_PHASE_STEP;
            restart_wave();
            expected_samples.delete();
        end else begin
            // compare first: a sample leaving now was never predicted at this edge
            if (samples.valid && samples.ready) begin
                if (expected_samples.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $error("sample: unexpected transaction, actual %0d",
                               $signed(samples.sample));
                end else begin
                    want = expected_samples.pop_front();
                    if (samples.sample !== want) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $error("sample: expected %0d, actual %0d",
                                   $signed(want), $signed(samples.sample));
                    end
                end
            end
            if (cfg.valid && cfg.ready)
                apply_write(cfg.index, cfg.data);
            if (ticks.valid && ticks.ready && ticks.tick)
                expected_samples.push_back(osc_next_sample());
        end
    end

endmodule

// ===== bench/multi_waveform_oscillator_core_tb.sv =====
// Top of the oscillator testbench: clock, reset, tick and register stimulus, sample sink.
// Depends on mwo_pkg, mwo_if, the core and mwo_sample_checker.
`timescale 1ns / 100ps

module multi_waveform_oscillator_core_tb;
    import mwo_pkg::*;

    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SAMPLE_BITS = 16;
    localparam int CLK_PERIOD = 8;
    localparam int RESET_CYCLES = 7;
    // time through the output register, plus margin for a dropped tick in flight
    localparam int SETTLE_CYCLES = 4;
    localparam int TICK_ITEMS = 1350;
    localparam longint TIMEOUT_NS = 64'd8_000_000;

    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;
    localparam logic [31:0] STEP_MAX = 32'd33554432;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;

    mwo_tick_if                          ticks_ch ();
    mwo_sample_if #(.W(SAMPLE_BITS))     samples_ch ();
    mwo_cfg_if                           cfg_ch ();

    multi_waveform_oscillator_core #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .ticks(ticks_ch),
        .samples(samples_ch),
        .cfg(cfg_ch)
    );

    mwo_sample_checker #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .ticks(ticks_ch),
        .samples(samples_ch),
        .cfg(cfg_ch),
        .errors(errors),
        .pending(pending)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Hard stop in case a handshake never completes
    initial begin
        #(TIMEOUT_NS);
        $display("FAILED: results differ");
        $finish;
    end

    // Sample sink: alternate ready-high and ready-low stretches of random length.
    // Stalls mostly draw from the short range; now and then a long one, and now and then
    // a long run with no stall at all.
    initial begin : sample_sink
        int  hold;
        bit  ready_next;
        samples_ch.ready = 1'b0;
        ready_next = 1'b0;
        hold = 0;
        forever begin
            @(negedge clk);
            if (hold == 0) begin
                ready_next = !ready_next;
                if (ready_next)
                    hold = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                       : $urandom_range(1, 12);
                else
                    hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(1, 3);
            end
            hold--;
            samples_ch.ready <= ready_next;
        end
    end

    // Idle cycles between tick transactions; a calm batch sends back to back
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Called at a falling edge. Leaves valid high afterwards when no gap follows,
    // so back-to-back transactions never lower and raise valid in one step.
    task automatic send_tick(input logic tick_bit, input bit calm);
        int gap;
        ticks_ch.valid <= 1'b1;
        ticks_ch.tick <= tick_bit;
        do @(posedge clk); while (!ticks_ch.ready);
        @(negedge clk);
        gap = pick_gap(calm);
        if (gap > 0) begin
            ticks_ch.valid <= 1'b0;
            ticks_ch.tick <= 1'($urandom);
            repeat (gap) @(negedge clk);
        end
    endtask

    // Send n ticks of 1, with dropped ticks of 0 sprinkled in, then drop valid
    task automatic send_batch(input int n, input bit calm);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0)
                send_tick(1'b0, calm);
            send_tick(1'b1, calm);
        end
        ticks_ch.valid <= 1'b0;
    endtask

    // Same convention as send_tick: the caller drops valid after the last write
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
    endtask

    // Hold until every predicted sample is out and a dropped tick has cleared
    task automatic wait_idle();
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [31:0] pick_cycle_len();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return COUNT_STEP;
        if (r == 1)
            return ALL_ONES;
        if (r == 2)
            return $urandom_range(0, 255);
        if (r < 6)
            return $urandom;
        return $urandom_range(1, 48) * 256 + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 0);
    endfunction

    function automatic logic [31:0] pick_span();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'd0;
        if (r == 1)
            return ALL_ONES;
        if (r == 2)
            return $urandom;
        return $urandom_range(0, 48) * 256 + $urandom_range(0, 255);
    endfunction

    function automatic logic [31:0] pick_step();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'd0;
        if (r == 1)
            return STEP_MAX;
        if (r == 2)
            return $urandom;
        return $urandom_range(32'h1_0000, 32'h40_0000);
    endfunction

    function automatic logic [31:0] pick_phase_step();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'd0;
        if (r == 1)
            return ALL_ONES;
        return $urandom;
    endfunction

    // Mode word; sometimes with junk in the bits above the mode field
    function automatic logic [31:0] pick_mode_word();
        logic [1:0] m;
        m = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0)
            return ($urandom & ~32'd3) | 32'(m);
        return 32'(m);
    endfunction

    initial begin : stimulus
        int unsigned ticks_sent;
        int n;
        logic [1:0] runaway_mode;

        rst_n = 1'b0;
        ticks_ch.valid = 1'b0;
        ticks_ch.tick = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed part ----
        // Reset defaults: sine at 1/100 turn per sample; a dropped tick first
        send_tick(1'b0, 1'b1);
        send_batch(3, 1'b1);

        // Pulse: half a two-sample cycle low, half high
        wait_idle();
        write_reg(REG_CYCLE_LEN, 32'd512);
        write_reg(REG_PULSE_LEN, 32'd256);
        write_reg(REG_WAVE_MODE, 32'(MODE_PULSE));
        cfg_ch.valid <= 1'b0;
        send_batch(4, 1'b0);

        // Pulse extremes: never low, then always low
        wait_idle();
        write_reg(REG_PULSE_LEN, 32'd0);
        cfg_ch.valid <= 1'b0;
        send_batch(2, 1'b1);
        wait_idle();
        write_reg(REG_PULSE_LEN, ALL_ONES);
        cfg_ch.valid <= 1'b0;
        send_batch(2, 1'b0);

        // Triangle with steps of STEP_MAX: the level overshoots and is clamped
        // back to full scale at each turning point
        wait_idle();
        write_reg(REG_CYCLE_LEN, 32'd1024);
        write_reg(REG_RISE_LEN, 32'd512);
        write_reg(REG_RISE_STEP, STEP_MAX);
        write_reg(REG_FALL_STEP, STEP_MAX);
        write_reg(REG_WAVE_MODE, 32'(MODE_TRIANGLE));
        cfg_ch.valid <= 1'b0;
        send_batch(4, 1'b1);

        // Sawtooth restarting every sample, then a cycle shorter than one sample
        wait_idle();
        write_reg(REG_CYCLE_LEN, COUNT_STEP);
        write_reg(REG_WAVE_MODE, 32'(MODE_SAW));
        cfg_ch.valid <= 1'b0;
        send_batch(2, 1'b0);
        wait_idle();
        write_reg(REG_CYCLE_LEN, 32'd100);
        cfg_ch.valid <= 1'b0;
        send_batch(2, 1'b1);

        // Sine with the largest phase step; a write to an unused index in between
        wait_idle();
        write_reg(REG_PHASE_STEP, ALL_ONES);
        write_reg(REG_UNUSED, ALL_ONES);
        write_reg(REG_WAVE_MODE, 32'(MODE_SINE));
        cfg_ch.valid <= 1'b0;
        send_batch(2, 1'b0);

        // ---- random part ----
        ticks_sent = 0;
        while (ticks_sent < TICK_ITEMS) begin
            wait_idle();
            if ($urandom_range(0, 9) == 0) begin
                // Runaway level: never turn, never wrap, so the level saturates
                runaway_mode = ($urandom_range(0, 1) == 0) ? MODE_TRIANGLE : MODE_SAW;
                write_reg(REG_CYCLE_LEN, ALL_ONES);
                write_reg(REG_RISE_LEN, ALL_ONES);
                write_reg(REG_RISE_STEP, STEP_MAX);
                write_reg(REG_FALL_STEP, STEP_MAX);
                write_reg(REG_WAVE_MODE, 32'(runaway_mode));
                n = $urandom_range(70, 120);
            end else begin
                if ($urandom_range(0, 1) == 0)
                    write_reg(REG_CYCLE_LEN, pick_cycle_len());
                if ($urandom_range(0, 1) == 0)
                    write_reg(REG_PULSE_LEN, pick_span());
                if ($urandom_range(0, 1) == 0)
                    write_reg(REG_RISE_LEN, pick_span());
                if ($urandom_range(0, 1) == 0)
                    write_reg(REG_RISE_STEP, pick_step());
                if ($urandom_range(0, 1) == 0)
                    write_reg(REG_FALL_STEP, pick_step());
                if ($urandom_range(0, 1) == 0)
                    write_reg(REG_PHASE_STEP, pick_phase_step());
                if ($urandom_range(0, 7) == 0)
                    write_reg(REG_UNUSED, $urandom);
                // most batches restart the waveform, the rest run on from where it was
                if ($urandom_range(0, 3) != 0)
                    write_reg(REG_WAVE_MODE, pick_mode_word());
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 160)
                                                : $urandom_range(8, 60);
            end
            cfg_ch.valid <= 1'b0;
            send_batch(n, $urandom_range(0, 3) == 0);
            ticks_sent += n;
        end

        // Drain, give the output register time to show anything stray, then judge
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES * 4) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== multi_waveform_oscillator_core.f =====
design/mwo_pkg.sv
design/mwo_if.sv
design/mwo_step.sv
design/multi_waveform_oscillator_core.sv
bench/mwo_sample_checker.sv
bench/multi_waveform_oscillator_core_tb.sv
